// ----- hw/rtl/sps_pkg.sv -----
// Shared types, constants and codes for the sparse polynomial combine block.
package sps_pkg;

	// Capacity default and key layout
	localparam int MAX_TERMS_DEF = 64;
	localparam int MAX_DIMS      = 4;
	localparam int EXP_BITS      = 8;

	// Register indexes of the configuration port
	localparam logic REG_SCALE = 1'b0;
	localparam logic REG_DIMS  = 1'b1;
	localparam logic [2:0] DIMS_RESET = 3'd4;

	// IEEE double constants
	localparam logic [62:0] SMALL_LIMIT = 63'h3D06849B86A12B9B; // 1e-14
	localparam logic [62:0] INF_MAG     = 63'h7FF0000000000000;
	localparam logic [63:0] DEFAULT_NAN = 64'hFFF8000000000000;

	// Working mantissa width of the floating-point unit
	localparam int FW = 110;

	typedef enum logic [1:0] {
		FOP_MUL = 2'b01,
		FOP_ADD = 2'b10
	} fpu_op_t;

	typedef enum logic [5:0] {
		F_IDLE   = 6'b000001,
		F_MUL    = 6'b000010,
		F_ALIGN  = 6'b000100,
		F_ADDSUB = 6'b001000,
		F_NORM   = 6'b010000,
		F_ROUND  = 6'b100000
	} fpu_state_t;

	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_SCALE    = 10'b0000000010,
		S_MUL      = 10'b0000000100,
		S_CHECK    = 10'b0000001000,
		S_SCAN_RD  = 10'b0000010000,
		S_SCAN_CMP = 10'b0000100000,
		S_ADD      = 10'b0001000000,
		S_TAIL     = 10'b0010000000,
		S_EMIT_RD  = 10'b0100000000,
		S_EMIT_CHK = 10'b1000000000
	} ctrl_state_t;

	typedef struct packed {
		logic [63:0] coeff_bits;
		logic [31:0] exponent_key;
		logic        from_second;
		logic        last_term;
	} in_t;

	typedef struct packed {
		logic [63:0] sum_bits;
		logic [31:0] key_out;
		logic        final_term;
		logic        is_empty;
		logic        overflowed;
	} out_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic mul_go;
		logic take_mul;
		logic idx_clr;
		logic idx_inc;
		logic rd;
		logic append;
		logic set_ovf;
		logic add_go;
		logic writeback;
		logic emit_take;
		logic flush;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic fpu_done;
		logic second;
		logic last;
		logic tiny;
		logic at_end;
		logic full;
		logic match;
	} sts_t;

endpackage

// ----- hw/rtl/sparse_poly_subtract_scaled.sv -----
// Top level of the sparse polynomial combine f - scale * g.
// A term is taken when start is high and busy is low; results come out as
// single-cycle beats on res marked by res_valid, and the receiver cannot hold
// them off. An f term keeps busy high while the stored slots are scanned for
// its key, one slot read and compared at a time; a term dropped as too small
// skips the scan. A match adds an IEEE double add in the shared FP unit,
// which settles infinite or NaN operands directly and otherwise runs its
// align, add, normalize and round steps. A g term first goes through that
// unit's multiply by minus scale, which settles zero, infinite or NaN operands
// directly and denormalizes a product that falls subnormal. The term flagged
// last then walks every stored slot and closes the run with a final beat.
module sparse_poly_subtract_scaled #(
	parameter int MAX_TERMS = sps_pkg::MAX_TERMS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sps_pkg::in_t  term,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [63:0]   cfg_data,
	output logic          res_valid,
	output sps_pkg::out_t res
);

	sps_pkg::cmd_t cmd;
	sps_pkg::sts_t sts;

	sps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	sps_dp #(
		.MAX_TERMS (MAX_TERMS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.term      (term),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule

// ----- hw/rtl/sps_fpu.sv -----
// Multi-cycle IEEE double multiply and add with round to nearest even.
module sps_fpu (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  sps_pkg::fpu_op_t      op,
	input  logic [63:0]           a,
	input  logic [63:0]           b,
	output logic                  done,
	output logic [63:0]           result
);

	localparam int W = sps_pkg::FW;

	sps_pkg::fpu_state_t st_q;
	logic                done_q;
	logic [63:0]         res_q;
	logic [W-1:0]        man_q;
	logic [W-1:0]        opb_q;
	logic signed [12:0]  exp_q;
	logic                sgn_q;
	logic                sgnb_q;
	logic [10:0]         sh_q;
	logic [52:0]         ma_q;
	logic [52:0]         mb_q;
	logic [2:0]          step_q;
	logic [53:0]         pp_q;
	logic [1:0]          ppsh_q;

	// Operand fields
	logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [10:0] ea, eb, eae, ebe;
	logic [52:0] ma, mb;
	always_comb begin
		sa = a[63];
		sb = b[63];
		ea = a[62:52];
		eb = b[62:52];
		a_nan  = (ea == 11'h7FF) && (a[51:0] != 52'd0);
		b_nan  = (eb == 11'h7FF) && (b[51:0] != 52'd0);
		a_inf  = (ea == 11'h7FF) && (a[51:0] == 52'd0);
		b_inf  = (eb == 11'h7FF) && (b[51:0] == 52'd0);
		a_zero = (ea == 11'd0) && (a[51:0] == 52'd0);
		b_zero = (eb == 11'd0) && (b[51:0] == 52'd0);
		ma  = {ea != 11'd0, a[51:0]};
		mb  = {eb != 11'd0, b[51:0]};
		eae = (ea == 11'd0) ? 11'd1 : ea;
		ebe = (eb == 11'd0) ? 11'd1 : eb;
	end

	// Partial product of one half pair
	logic [26:0]  pa, pb;
	logic [53:0]  prod;
	logic [W-1:0] pp_ext;
	always_comb begin
		pa = step_q[1] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
		pb = step_q[0] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
		prod = pa * pb;
		case (ppsh_q)
			2'd2:    pp_ext = W'(pp_q) << 54;
			2'd1:    pp_ext = W'(pp_q) << 27;
			default: pp_ext = W'(pp_q);
		endcase
	end

	// Rounding of the normalized mantissa
	logic [52:0] m53;
	logic        grd, stk, inc;
	logic [10:0] efield;
	logic [62:0] mag;
	always_comb begin
		m53 = man_q[W-1:W-53];
		grd = man_q[W-54];
		stk = |man_q[W-55:0];
		inc = grd & (stk | m53[0]);
		efield = man_q[W-1] ? exp_q[10:0] : 11'd0;
		mag = {efield, m53[51:0]} + 63'(inc);
	end

	logic ge_ab;
	assign ge_ab = man_q >= opb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= sps_pkg::F_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				sps_pkg::F_IDLE: begin
					if (go && op == sps_pkg::FOP_MUL) begin
						if (a_nan) begin
							res_q <= a | 64'h0008000000000000; done_q <= 1'b1;
						end else if (b_nan) begin
							res_q <= b | 64'h0008000000000000; done_q <= 1'b1;
						end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
							res_q <= sps_pkg::DEFAULT_NAN; done_q <= 1'b1;
						end else if (a_inf || b_inf) begin
							res_q <= {sa ^ sb, sps_pkg::INF_MAG}; done_q <= 1'b1;
						end else if (a_zero || b_zero) begin
							res_q <= {sa ^ sb, 63'd0}; done_q <= 1'b1;
						end else begin
							man_q  <= '0;
							exp_q  <= 13'(eae) + 13'(ebe) - 13'd1018;
							sgn_q  <= sa ^ sb;
							ma_q   <= ma;
							mb_q   <= mb;
							step_q <= 3'd0;
							st_q   <= sps_pkg::F_MUL;
						end
					end else if (go) begin
						if (a_nan) begin
							res_q <= a | 64'h0008000000000000; done_q <= 1'b1;
						end else if (b_nan) begin
							res_q <= b | 64'h0008000000000000; done_q <= 1'b1;
						end else if (a_inf && b_inf && (sa != sb)) begin
							res_q <= sps_pkg::DEFAULT_NAN; done_q <= 1'b1;
						end else if (a_inf) begin
							res_q <= a; done_q <= 1'b1;
						end else if (b_inf) begin
							res_q <= b; done_q <= 1'b1;
						end else if (eae >= ebe) begin
							man_q  <= {1'b0, ma, 56'd0};
							opb_q  <= {1'b0, mb, 56'd0};
							exp_q  <= 13'(eae) + 13'd1;
							sh_q   <= eae - ebe;
							sgn_q  <= sa;
							sgnb_q <= sb;
							st_q   <= sps_pkg::F_ALIGN;
						end else begin
							man_q  <= {1'b0, mb, 56'd0};
							opb_q  <= {1'b0, ma, 56'd0};
							exp_q  <= 13'(ebe) + 13'd1;
							sh_q   <= ebe - eae;
							sgn_q  <= sb;
							sgnb_q <= sa;
							st_q   <= sps_pkg::F_ALIGN;
						end
					end
				end
				sps_pkg::F_MUL: begin
					// Multiply one half pair, accumulate the previous one
					if (step_q != 3'd4) begin
						pp_q   <= prod;
						ppsh_q <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
					end
					if (step_q != 3'd0)
						man_q <= man_q + pp_ext;
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4)
						st_q <= sps_pkg::F_NORM;
				end
				sps_pkg::F_ALIGN: begin
					// Shift the smaller operand right, keep a sticky bit
					if (sh_q == 11'd0) begin
						st_q <= sps_pkg::F_ADDSUB;
					end else if (sh_q >= 11'(W)) begin
						opb_q <= {{(W-1){1'b0}}, |opb_q};
						sh_q  <= 11'd0;
					end else if (sh_q >= 11'd16) begin
						opb_q <= {16'd0, opb_q[W-1:17], |opb_q[16:0]};
						sh_q  <= sh_q - 11'd16;
					end else begin
						opb_q <= {1'b0, opb_q[W-1:2], |opb_q[1:0]};
						sh_q  <= sh_q - 11'd1;
					end
				end
				sps_pkg::F_ADDSUB: begin
					if (sgn_q == sgnb_q) begin
						man_q <= man_q + opb_q;
					end else if (ge_ab) begin
						man_q <= man_q - opb_q;
						if (man_q == opb_q)
							sgn_q <= 1'b0;
					end else begin
						man_q <= opb_q - man_q;
						sgn_q <= sgnb_q;
					end
					st_q <= sps_pkg::F_NORM;
				end
				sps_pkg::F_NORM: begin
					if (man_q == '0) begin
						res_q  <= {sgn_q, 63'd0};
						done_q <= 1'b1;
						st_q   <= sps_pkg::F_IDLE;
					end else if (!man_q[W-1] && exp_q > 13'sd1) begin
						if (man_q[W-1:W-16] == 16'd0 && exp_q > 13'sd16) begin
							man_q <= man_q << 16;
							exp_q <= exp_q - 13'sd16;
						end else begin
							man_q <= man_q << 1;
							exp_q <= exp_q - 13'sd1;
						end
					end else if (exp_q < 13'sd1) begin
						// Denormalize toward the minimum exponent
						if (exp_q < $signed(13'(1 - W))) begin
							man_q <= {{(W-1){1'b0}}, |man_q};
							exp_q <= 13'sd1;
						end else if (exp_q < -13'sd14) begin
							man_q <= {16'd0, man_q[W-1:17], |man_q[16:0]};
							exp_q <= exp_q + 13'sd16;
						end else begin
							man_q <= {1'b0, man_q[W-1:2], |man_q[1:0]};
							exp_q <= exp_q + 13'sd1;
						end
					end else begin
						st_q <= sps_pkg::F_ROUND;
					end
				end
				sps_pkg::F_ROUND: begin
					if (man_q[W-1] && exp_q > 13'sd2046)
						res_q <= {sgn_q, sps_pkg::INF_MAG};
					else
						res_q <= {sgn_q, mag};
					done_q <= 1'b1;
					st_q   <= sps_pkg::F_IDLE;
				end
				default: st_q <= sps_pkg::F_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ----- hw/rtl/sps_dp.sv -----
// Datapath: term registers, slot memories, key match, FP unit and output beat.
module sps_dp #(
	parameter int MAX_TERMS = sps_pkg::MAX_TERMS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sps_pkg::in_t       term,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [63:0]        cfg_data,
	input  sps_pkg::cmd_t      cmd,
	output sps_pkg::sts_t      sts,
	output logic               res_valid,
	output sps_pkg::out_t      res
);

	localparam int AW = $clog2(MAX_TERMS);
	localparam int CW = $clog2(MAX_TERMS + 1);

	logic [63:0]   scale_q;
	logic [2:0]    dims_q;
	logic [63:0]   coeff_q;
	logic [31:0]   key_q;
	logic          second_q;
	logic          last_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [CW-1:0] idx_q;
	logic [31:0]   rd_key_q;
	logic [63:0]   rd_sum_q;
	logic          pend_valid_q;
	logic [63:0]   pend_sum_q;
	logic [31:0]   pend_key_q;
	logic          res_valid_q;
	sps_pkg::out_t res_q;

	logic [31:0] key_mem [MAX_TERMS];
	logic [63:0] sum_mem [MAX_TERMS];

	// Floating-point unit: multiply by minus scale, or accumulate into a slot
	logic             fpu_go, fpu_done;
	sps_pkg::fpu_op_t fpu_op;
	logic [63:0]      fpu_a, fpu_res;
	assign fpu_go = cmd.mul_go | cmd.add_go;
	assign fpu_op = cmd.add_go ? sps_pkg::FOP_ADD : sps_pkg::FOP_MUL;
	assign fpu_a  = cmd.add_go ? rd_sum_q : {~scale_q[63], scale_q[62:0]};

	sps_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (fpu_go),
		.op     (fpu_op),
		.a      (fpu_a),
		.b      (coeff_q),
		.done   (fpu_done),
		.result (fpu_res)
	);

	// Lane mask over the lanes in use
	logic [3:0]  lanes;
	logic [7:0]  lane_bits;
	logic [31:0] mask;
	always_comb begin
		lanes = ({1'b0, dims_q} > 4'(sps_pkg::MAX_DIMS)) ? 4'(sps_pkg::MAX_DIMS)
			: {1'b0, dims_q};
		lane_bits = 8'(lanes) * 8'(sps_pkg::EXP_BITS);
		for (int j = 0; j < 32; j++)
			mask[j] = 8'(j) < lane_bits;
	end

	logic big;
	assign big = (rd_sum_q[62:0] >= sps_pkg::SMALL_LIMIT) && (rd_sum_q[62:0] <= sps_pkg::INF_MAG);

	always_comb begin
		sts.fpu_done = fpu_done;
		sts.second   = second_q;
		sts.last     = last_q;
		sts.tiny     = coeff_q[62:0] < sps_pkg::SMALL_LIMIT;
		sts.at_end   = idx_q == count_q;
		sts.full     = count_q == CW'(MAX_TERMS);
		sts.match    = ((rd_key_q ^ key_q) & mask) == 32'd0;
	end

	// Slot memories
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			key_mem[count_q[AW-1:0]] <= key_q;
			sum_mem[count_q[AW-1:0]] <= coeff_q;
		end else if (cmd.writeback) begin
			sum_mem[idx_q[AW-1:0]] <= fpu_res;
		end
		if (cmd.rd) begin
			rd_key_q <= key_mem[idx_q[AW-1:0]];
			rd_sum_q <= sum_mem[idx_q[AW-1:0]];
		end
	end

	// Term payload and pending output
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			coeff_q  <= term.coeff_bits;
			key_q    <= term.exponent_key;
			second_q <= term.from_second;
			last_q   <= term.last_term;
		end else if (cmd.take_mul) begin
			coeff_q <= fpu_res;
		end
		if (cmd.emit_take && big) begin
			pend_sum_q <= rd_sum_q;
			pend_key_q <= rd_key_q;
		end
		if (cmd.emit_take && big) begin
			res_q <= '{sum_bits: pend_sum_q, key_out: pend_key_q, final_term: 1'b0,
				is_empty: 1'b0, overflowed: ovf_q};
		end else if (cmd.flush) begin
			if (pend_valid_q)
				res_q <= '{sum_bits: pend_sum_q, key_out: pend_key_q, final_term: 1'b1,
					is_empty: 1'b0, overflowed: ovf_q};
			else
				res_q <= '{sum_bits: 64'd0, key_out: 32'd0, final_term: 1'b1,
					is_empty: 1'b1, overflowed: ovf_q};
		end
	end

	// Configuration, slot count, scan index and output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q      <= 64'd0;
			dims_q       <= sps_pkg::DIMS_RESET;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == sps_pkg::REG_SCALE)
				scale_q <= cfg_data;
			if (cfg_we && cfg_index == sps_pkg::REG_DIMS)
				dims_q <= cfg_data[2:0];
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + CW'(1);
			if (cmd.append)
				count_q <= count_q + CW'(1);
			if (cmd.set_ovf)
				ovf_q <= 1'b1;
			res_valid_q <= (cmd.emit_take && big && pend_valid_q) || cmd.flush;
			if (cmd.emit_take && big)
				pend_valid_q <= 1'b1;
			if (cmd.flush) begin
				count_q      <= '0;
				ovf_q        <= 1'b0;
				pend_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- hw/rtl/sps_ctrl.sv -----
// Controller: sequences scaling, slot scan, accumulate and emission per term.
module sps_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  sps_pkg::sts_t sts,
	output sps_pkg::cmd_t cmd,
	output logic          busy
);

	sps_pkg::ctrl_state_t state_q, state_d;
	logic                 flush_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			sps_pkg::S_IDLE: begin
				if (flush_q) begin
					cmd.flush = 1'b1;
				end else if (start) begin
					cmd.load = 1'b1;
					state_d  = sps_pkg::S_SCALE;
				end
			end
			sps_pkg::S_SCALE: begin
				if (sts.second) begin
					cmd.mul_go = 1'b1;
					state_d    = sps_pkg::S_MUL;
				end else begin
					state_d = sps_pkg::S_CHECK;
				end
			end
			sps_pkg::S_MUL: begin
				if (sts.fpu_done) begin
					cmd.take_mul = 1'b1;
					state_d      = sps_pkg::S_CHECK;
				end
			end
			sps_pkg::S_CHECK: begin
				cmd.idx_clr = 1'b1;
				state_d = sts.tiny ? sps_pkg::S_TAIL : sps_pkg::S_SCAN_RD;
			end
			sps_pkg::S_SCAN_RD: begin
				if (sts.at_end) begin
					cmd.append  = !sts.full;
					cmd.set_ovf = sts.full;
					state_d     = sps_pkg::S_TAIL;
				end else begin
					cmd.rd  = 1'b1;
					state_d = sps_pkg::S_SCAN_CMP;
				end
			end
			sps_pkg::S_SCAN_CMP: begin
				if (sts.match) begin
					cmd.add_go = 1'b1;
					state_d    = sps_pkg::S_ADD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = sps_pkg::S_SCAN_RD;
				end
			end
			sps_pkg::S_ADD: begin
				if (sts.fpu_done) begin
					cmd.writeback = 1'b1;
					state_d       = sps_pkg::S_TAIL;
				end
			end
			sps_pkg::S_TAIL: begin
				cmd.idx_clr = 1'b1;
				state_d = sts.last ? sps_pkg::S_EMIT_RD : sps_pkg::S_IDLE;
			end
			sps_pkg::S_EMIT_RD: begin
				if (sts.at_end) begin
					state_d = sps_pkg::S_IDLE;
				end else begin
					cmd.rd  = 1'b1;
					state_d = sps_pkg::S_EMIT_CHK;
				end
			end
			sps_pkg::S_EMIT_CHK: begin
				cmd.emit_take = 1'b1;
				cmd.idx_inc   = 1'b1;
				state_d       = sps_pkg::S_EMIT_RD;
			end
			default: state_d = sps_pkg::S_IDLE;
		endcase
	end

	// Hold busy through the closing beat of a run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sps_pkg::S_IDLE;
			flush_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sps_pkg::S_EMIT_RD && sts.at_end)
				flush_q <= 1'b1;
			else if (state_q == sps_pkg::S_IDLE)
				flush_q <= 1'b0;
		end
	end

	assign busy = (state_q != sps_pkg::S_IDLE) || flush_q;

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the sparse polynomial combine f - scale * g.
`timescale 1ns / 1ps

module tb;

	localparam int SLOTS      = sps_pkg::MAX_TERMS_DEF;
	localparam int CYCLE_CAP  = 1000000;
	localparam int SETTLE     = 40;
	localparam logic [63:0] LANE_BYTE = 64'hFF;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         start = 1'b0;
	logic         busy;
	sps_pkg::in_t term = '0;
	logic         cfg_we = 1'b0;
	logic         cfg_index = sps_pkg::REG_SCALE;
	logic [63:0]  cfg_data = '0;
	logic         res_valid;
	sps_pkg::out_t res;

	// Shadow registers, slot contents and expected beats
	logic [63:0]   scale_shadow = 64'd0;
	logic [2:0]    dims_shadow = sps_pkg::DIMS_RESET;
	logic [31:0]   slot_key [SLOTS];
	real           slot_sum [SLOTS];
	int            slots_used = 0;
	bit            ovf_flag = 1'b0;
	sps_pkg::in_t  pending_terms [$];
	sps_pkg::out_t expected_beats [$];
	int            gap_left = 0;
	bit            calm = 1'b0;
	int            errors = 0;
	int            cycles = 0;
	int            terms_taken = 0;
	int            beats_seen = 0;
	int            runs_closed = 0;
	logic [63:0]   prev_coeff = 64'h3FF0000000000000;

	sparse_poly_subtract_scaled dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .term(term),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.res_valid(res_valid), .res(res)
	);

	always #10 clk = ~clk;

	function automatic logic [31:0] lane_mask(logic [2:0] dims);
		logic [31:0] m;
		int lanes;
		m = '0;
		lanes = (dims > sps_pkg::MAX_DIMS) ? sps_pkg::MAX_DIMS : dims;
		for (int l = 0; l < lanes; l++) m |= 32'(LANE_BYTE << (l * sps_pkg::EXP_BITS));
		return m;
	endfunction

	function automatic bit below_limit(logic [63:0] b);
		return b[62:0] < sps_pkg::SMALL_LIMIT;
	endfunction

	// Fold one accepted term into the slots; on the last term queue the run's beats
	task automatic combine_term(sps_pkg::in_t t);
		real c;
		bit found;
		int first, n;
		sps_pkg::out_t o;
		c = $bitstoreal(t.coeff_bits);
		if (t.from_second) c = (-$bitstoreal(scale_shadow)) * c;
		if (!below_limit($realtobits(c))) begin
			found = 1'b0;
			for (int i = 0; i < slots_used; i++) begin
				if (!found && ((slot_key[i] ^ t.exponent_key) & lane_mask(dims_shadow)) == 0) begin
					slot_sum[i] = slot_sum[i] + c;
					found = 1'b1;
				end
			end
			if (!found) begin
				if (slots_used < SLOTS) begin
					slot_key[slots_used] = t.exponent_key;
					slot_sum[slots_used] = c;
					slots_used++;
				end else begin
					ovf_flag = 1'b1;
				end
			end
		end
		if (t.last_term) begin
			first = expected_beats.size();
			n = 0;
			for (int i = 0; i < slots_used; i++) begin
				o = '0;
				o.sum_bits = $realtobits(slot_sum[i]);
				// drop small sums and NaN sums
				if (!below_limit(o.sum_bits) && o.sum_bits[62:0] <= sps_pkg::INF_MAG) begin
					o.key_out = slot_key[i];
					o.overflowed = ovf_flag;
					expected_beats.push_back(o);
					n++;
				end
			end
			if (n == 0) begin
				o = '0;
				o.final_term = 1'b1;
				o.is_empty = 1'b1;
				o.overflowed = ovf_flag;
				expected_beats.push_back(o);
			end else begin
				expected_beats[first + n - 1].final_term = 1'b1;
			end
			slots_used = 0;
			ovf_flag = 1'b0;
			runs_closed++;
		end
	endtask

	// Driver: present the next pending term after a random gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else if (!start || !busy) begin
			if (start) begin
				combine_term(term);
				terms_taken++;
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_terms.size() > 0) begin
				term <= pending_terms.pop_front();
				start <= 1'b1;
				if ($urandom_range(0, 15) == 0) calm = ~calm;
				gap_left <= calm ? 0 : $urandom_range(0, 9);
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic report(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: mismatch on %s: expected %h, got %h", $time, field, want, got);
			errors++;
		end
	endtask

	// Monitor: check every result beat against the oldest expectation
	always @(posedge clk) begin
		sps_pkg::out_t want;
		if (arst_n && res_valid) begin
			beats_seen++;
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected beat: expected none, got %h", $time, res);
				errors++;
			end else begin
				want = expected_beats.pop_front();
				report("sum_bits", want.sum_bits, res.sum_bits);
				report("key_out", 64'(want.key_out), 64'(res.key_out));
				report("final_term", 64'(want.final_term), 64'(res.final_term));
				report("is_empty", 64'(want.is_empty), 64'(res.is_empty));
				report("overflowed", 64'(want.overflowed), 64'(res.overflowed));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic add_term(logic [63:0] c, logic [31:0] k, bit g, bit last);
		sps_pkg::in_t t;
		t.coeff_bits = c;
		t.exponent_key = k;
		t.from_second = g;
		t.last_term = last;
		pending_terms.push_back(t);
	endtask

	function automatic logic [63:0] rand_coeff();
		logic [63:0] c;
		int pick;
		pick = $urandom_range(0, 99);
		c = {$urandom, $urandom};
		if (pick < 60) c[62:52] = 11'($urandom_range(1015, 1031));
		else if (pick < 70) c[62:52] = 11'($urandom_range(960, 985));
		else if (pick < 85) c = prev_coeff ^ 64'h8000000000000000;
		else if (pick < 90) c = {c[63], 11'h7FF, (pick[0] ? 52'd0 : c[51:0])};
		prev_coeff = c;
		return c;
	endfunction

	// One run of random terms drawn mostly from a small key pool
	task automatic add_run(int len);
		logic [31:0] pool [4];
		logic [31:0] k;
		for (int i = 0; i < 4; i++) pool[i] = $urandom;
		for (int i = 0; i < len; i++) begin
			k = pool[$urandom_range(0, 3)];
			if ($urandom_range(0, 3) == 0) k ^= $urandom & ~lane_mask(dims_shadow);
			if ($urandom_range(0, 9) == 0) k = $urandom;
			add_term(rand_coeff(), k, 1'($urandom_range(0, 1)), i == len - 1);
		end
	endtask

	// Distinct keys beyond capacity, then two more new keys, the second closing the run
	task automatic add_overflow_run();
		for (int i = 0; i < SLOTS + 4; i++)
			add_term(rand_coeff() | 64'h3FF0000000000000, {24'($urandom), 8'(i)},
				1'($urandom_range(0, 1)), 1'b0);
		add_term(64'h4000000000000000, 32'h00000003, 1'b0, 1'b0);
		add_term(64'hC008000000000000, 32'h00000005, 1'b1, 1'b1);
	endtask

	task automatic wait_idle();
		while (pending_terms.size() > 0 || start || expected_beats.size() > 0 || busy)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [63:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == sps_pkg::REG_SCALE) scale_shadow = value;
		else dims_shadow = value[2:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [63:0] scales [6];
		logic [2:0]  dims [6];
		scales = '{64'hBFF0000000000000, 64'h7FEFFFFFFFFFFFFF, 64'h3FE0000000000000,
			64'h0000000000000000, 64'hFFFFFFFFFFFFFFFF, 64'h4004000000000000};
		dims = '{3'd1, 3'd4, 3'd2, 3'd0, 3'd7, 3'd3};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: cancellation, drops, infinity, NaN, lane masking, empty run
		write_reg(sps_pkg::REG_SCALE, 64'h3FF8000000000000);
		write_reg(sps_pkg::REG_DIMS, 64'd4);
		add_term(64'h4008000000000000, 32'h01020304, 1'b0, 1'b0);
		add_term(64'h4000000000000000, 32'h01020304, 1'b1, 1'b0);
		add_term(64'h3CD203AF9EE75616, 32'h11111111, 1'b0, 1'b0);
		add_term(64'h7FEFFFFFFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0);
		add_term(64'h7FEFFFFFFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0);
		add_term(64'h7FF8000000000001, 32'h00000000, 1'b1, 1'b0);
		add_term(64'h8000000000000000, 32'h22222222, 1'b0, 1'b0);
		add_term(64'h0000000000000001, 32'h33333333, 1'b1, 1'b0);
		add_term(64'hFFF0000000000000, 32'h44444444, 1'b0, 1'b0);
		add_term(64'h3D06849B86A12B9B, 32'h55555555, 1'b0, 1'b0);
		add_term(64'h3FF0000000000000, 32'h55555555, 1'b1, 1'b0);
		add_term(64'hC000000000000000, 32'h00000000, 1'b1, 1'b1);
		add_term(64'h3CB0000000000000, 32'h01010101, 1'b0, 1'b1);
		add_term(64'h0000000000000000, 32'h00000000, 1'b0, 1'b1);
		wait_idle();
		write_reg(sps_pkg::REG_DIMS, 64'd1);
		add_term(64'h4014000000000000, 32'hAABBCC07, 1'b0, 1'b0);
		add_term(64'h3FF0000000000000, 32'h12345607, 1'b1, 1'b0);
		add_term(64'hBFF0000000000000, 32'h12345608, 1'b0, 1'b1);
		wait_idle();
		write_reg(sps_pkg::REG_DIMS, 64'd0);
		add_term(64'h4014000000000000, 32'h00000000, 1'b0, 1'b0);
		add_term(64'h4000000000000000, 32'hFFFFFFFF, 1'b0, 1'b1);
		wait_idle();

		// Random phases over several register settings
		for (int p = 0; p < 6; p++) begin
			write_reg(sps_pkg::REG_SCALE, (p == 5) ? {$urandom, $urandom} : scales[p]);
			write_reg(sps_pkg::REG_DIMS, {61'($urandom), dims[p]});
			for (int r = 0; r < 3; r++) add_run($urandom_range(1, 7));
			if (p == 1) add_overflow_run();
			wait_idle();
		end

		$display("Covered %0d terms in %0d runs, %0d result beats checked.",
			terms_taken, runs_closed, beats_seen);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
